FILE: hdl/lzwd_pkg.sv
// Shared types and constants for the LZ window decompressor.
// Used by lzwd_ctrl, lzwd_dp and the top level; no dependencies.
package lzwd_pkg;

    localparam int HISTORY_DEPTH = 4096;
    localparam int MAX_COPY      = 16;
    localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
    localparam int LEN_W         = $clog2(MAX_COPY);
    localparam int BYTE_W        = 8;
    localparam int DIST_W        = 12;
    localparam int FLAG_CNT_W    = 3;

    localparam logic [HIST_AW:0] FILL_FULL = (HIST_AW + 1)'(HISTORY_DEPTH);

    typedef enum logic [1:0] {
        PH_FLAG  = 2'd0,
        PH_TOKEN = 2'd1,
        PH_MATCH = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_COPY_RD = 2'd1,
        ST_COPY_WR = 2'd2
    } t_state;

    typedef struct packed {
        logic take_flag;
        logic take_dist_high;
        logic take_literal;
        logic take_end;
        logic start_copy;
        logic copy_step;
    } t_cmd;

    typedef struct packed {
        t_phase phase;
        logic   flag_match;
        logic   len_zero;
        logic   remain_zero;
        logic   out_free;
    } t_stat;

endpackage

FILE: hdl/lzwd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lzwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/lzwd_dp.sv
// Datapath: parse registers, history ring, copy pointers and output register.
// Depends on lzwd_pkg and lzwd_ram.
module lzwd_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [lzwd_pkg::BYTE_W-1:0]  i_s_tdata,
    input  lzwd_pkg::t_cmd               i_cmd,
    output lzwd_pkg::t_stat              o_stat,
    input  logic                         i_m_tready,
    output logic                         o_m_tvalid,
    output logic [lzwd_pkg::BYTE_W-1:0]  o_m_tdata,
    output logic                         o_m_tlast,
    output logic                         o_m_tuser
);

    lzwd_pkg::t_phase                     r_phase, n_phase;
    logic [lzwd_pkg::BYTE_W-1:0]          r_flag, n_flag;
    logic [lzwd_pkg::FLAG_CNT_W-1:0]      r_count, n_count;
    logic [lzwd_pkg::BYTE_W-1:0]          r_dist_high, n_dist_high;
    logic [lzwd_pkg::HIST_AW-1:0]         r_wslot, n_wslot;
    logic [lzwd_pkg::HIST_AW:0]           r_fill, n_fill;
    logic [lzwd_pkg::HIST_AW-1:0]         r_src, n_src;
    logic [lzwd_pkg::LEN_W-1:0]           r_remain, n_remain;
    logic                                 r_rd_valid;
    logic                                 r_out_valid, n_out_valid;
    logic [lzwd_pkg::BYTE_W-1:0]          r_out_byte, n_out_byte;
    logic                                 r_out_last, n_out_last;
    logic                                 r_out_end, n_out_end;

    logic [lzwd_pkg::DIST_W-1:0]          w_dist;
    logic [lzwd_pkg::BYTE_W-1:0]          w_rdata;
    logic [lzwd_pkg::BYTE_W-1:0]          w_copy_byte;
    logic [lzwd_pkg::BYTE_W-1:0]          w_wdata;
    logic                                 w_we;
    logic                                 w_finish;
    logic [lzwd_pkg::FLAG_CNT_W-1:0]      w_count_inc;

    assign w_dist      = {r_dist_high, i_s_tdata[7:4]};
    // Slots past the fill level were never written: they read as zero.
    assign w_copy_byte = r_rd_valid ? w_rdata : '0;
    assign w_we        = i_cmd.take_literal | i_cmd.copy_step;
    assign w_wdata     = i_cmd.take_literal ? i_s_tdata : w_copy_byte;
    assign w_finish    = i_cmd.take_literal | (i_cmd.copy_step & (r_remain == '0));
    assign w_count_inc = r_count + 1'b1;

    lzwd_ram #(
        .WIDTH (lzwd_pkg::BYTE_W),
        .DEPTH (lzwd_pkg::HISTORY_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_wslot),
        .i_wdata (w_wdata),
        .i_raddr (r_src),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_phase     = r_phase;
        n_flag      = r_flag;
        n_count     = r_count;
        n_dist_high = r_dist_high;
        n_wslot     = r_wslot;
        n_fill      = r_fill;
        n_src       = r_src;
        n_remain    = r_remain;
        n_out_valid = r_out_valid & ~i_m_tready;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        n_out_end   = r_out_end;

        if (i_cmd.take_flag) begin
            n_flag  = i_s_tdata;
            n_count = '0;
            n_phase = lzwd_pkg::PH_TOKEN;
        end
        if (i_cmd.take_dist_high) begin
            n_dist_high = i_s_tdata;
            n_phase     = lzwd_pkg::PH_MATCH;
        end
        if (i_cmd.take_end) begin
            n_phase     = lzwd_pkg::PH_FLAG;
            n_count     = '0;
            n_flag      = '0;
            n_out_valid = 1'b1;
            n_out_byte  = '0;
            n_out_last  = 1'b1;
            n_out_end   = 1'b1;
        end
        if (i_cmd.start_copy) begin
            n_src    = r_wslot - lzwd_pkg::HIST_AW'(w_dist);
            n_remain = i_s_tdata[lzwd_pkg::LEN_W-1:0];
        end
        if (i_cmd.copy_step) begin
            n_src    = r_src + 1'b1;
            n_remain = r_remain - 1'b1;
        end
        if (w_we) begin
            n_wslot     = r_wslot + 1'b1;
            n_out_valid = 1'b1;
            n_out_byte  = w_wdata;
            n_out_last  = i_cmd.take_literal | (r_remain == '0);
            n_out_end   = 1'b0;
            if (r_fill != lzwd_pkg::FILL_FULL) begin
                n_fill = r_fill + 1'b1;
            end
        end
        if (w_finish) begin
            n_flag  = r_flag >> 1;
            n_count = w_count_inc;
            n_phase = (w_count_inc == '0) ? lzwd_pkg::PH_FLAG : lzwd_pkg::PH_TOKEN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= lzwd_pkg::PH_FLAG;
            r_flag      <= '0;
            r_count     <= '0;
            r_dist_high <= '0;
            r_wslot     <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_flag      <= n_flag;
            r_count     <= n_count;
            r_dist_high <= n_dist_high;
            r_wslot     <= n_wslot;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src      <= n_src;
        r_remain   <= n_remain;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
        r_out_end  <= n_out_end;
        // Sample alongside the RAM read so the flag matches its data.
        r_rd_valid <= ({1'b0, r_src} < r_fill);
    end

    assign o_stat.phase       = r_phase;
    assign o_stat.flag_match  = r_flag[0];
    assign o_stat.len_zero    = (i_s_tdata[lzwd_pkg::LEN_W-1:0] == '0);
    assign o_stat.remain_zero = (r_remain == '0);
    assign o_stat.out_free    = ~r_out_valid | i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_byte;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_end;

endmodule

FILE: hdl/lzwd_ctrl.sv
// Controller: accepts compressed words and sequences match copies.
// Depends on lzwd_pkg.
module lzwd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  lzwd_pkg::t_stat i_stat,
    output lzwd_pkg::t_cmd  o_cmd
);

    lzwd_pkg::t_state r_state, n_state;
    logic             w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lzwd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        w_accept   = 1'b0;
        unique case (r_state)
            lzwd_pkg::ST_IDLE: begin
                // Take a word only when the output register can hold its result.
                o_s_tready = i_stat.out_free;
                w_accept   = i_s_tvalid & i_stat.out_free;
                if (w_accept) begin
                    unique case (i_stat.phase)
                        lzwd_pkg::PH_TOKEN: begin
                            if (i_stat.flag_match) begin
                                o_cmd.take_dist_high = 1'b1;
                            end else begin
                                o_cmd.take_literal = 1'b1;
                            end
                        end
                        lzwd_pkg::PH_MATCH: begin
                            if (i_stat.len_zero) begin
                                o_cmd.take_end = 1'b1;
                            end else begin
                                o_cmd.start_copy = 1'b1;
                                n_state          = lzwd_pkg::ST_COPY_RD;
                            end
                        end
                        default: begin
                            o_cmd.take_flag = 1'b1;
                        end
                    endcase
                end
            end
            lzwd_pkg::ST_COPY_RD: begin
                n_state = lzwd_pkg::ST_COPY_WR;
            end
            lzwd_pkg::ST_COPY_WR: begin
                // Hold the byte until the output register frees up.
                if (i_stat.out_free) begin
                    o_cmd.copy_step = 1'b1;
                    n_state = i_stat.remain_zero ? lzwd_pkg::ST_IDLE : lzwd_pkg::ST_COPY_RD;
                end
            end
            default: begin
                n_state = lzwd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/lz_window_decompressor.sv
// LZ window decompressor with a 4096-byte history ring and 2..16 byte matches.
// Usage: compressed bytes enter on the s channel (tdata = in_byte), one word
// per handshake. A flag byte precedes each group of eight tokens, LSB first.
// Decompressed bytes leave on the m channel: tdata = out_byte, tlast marks
// the last byte caused by one input word, tuser marks the end-of-stream word
// (tdata zero then). Flag bytes and first match bytes yield no output.
// A literal is registered and appears on the m channel in the cycle after
// acceptance. A match copies its bytes after its second byte, each with one
// ring read (ST_COPY_RD) and one ring write (ST_COPY_WR) through the
// single-port-pair history RAM; a stalled receiver holds the write.
// Input is taken only between tokens and when the output register is empty
// or draining, so a stalled receiver holds the current word and stops input.
// Reset is synchronous, active low: the parser expects a flag byte and the
// ring reads as zeros; a fill counter masks slots not yet written, so no
// clearing pass is needed before the block accepts input.
// Depends on lzwd_pkg, lzwd_ctrl, lzwd_dp and lzwd_ram.
module lz_window_decompressor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] in_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] out_byte
    output logic        o_m_tlast,   // run_last
    output logic        o_m_tuser    // [0] stream_end
);

    lzwd_pkg::t_cmd  w_cmd;
    lzwd_pkg::t_stat w_stat;

    lzwd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    lzwd_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

`ifndef SYNTHESIS
    a_no_accept_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |-> (!o_m_tvalid || i_m_tready))
        else $error("input word accepted while output word stalled");

    a_end_marker_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tlast && (o_m_tdata == 8'd0)))
        else $error("end marker without last flag or with nonzero data");

    a_no_accept_in_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.copy_step |-> !o_s_tready)
        else $error("input ready during match copy");

    a_copy_output_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.copy_step || w_cmd.take_literal || w_cmd.take_end) |=> o_m_tvalid)
        else $error("result not loaded into output register");
`endif

endmodule
